// ----- rtl/pwm_ramp_steering_mixer_assert.svh -----
// Assertion macros used by the drive mixer checker.
`ifndef PWM_RAMP_STEERING_MIXER_ASSERT_SVH
`define PWM_RAMP_STEERING_MIXER_ASSERT_SVH

// Checks a consequent in the same cycle as its antecedent.
`define PRSM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("drive mixer check failed");

// Checks a consequent in the cycle after its antecedent.
`define PRSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("drive mixer check failed");

`endif

// ----- rtl/prsm_pkg.sv -----
// Types and constants shared by the drive mixer modules.
`timescale 1ns / 1ps

package prsm_pkg;

    // Fixed scale factors of the drive law.
    localparam logic [22:0] MS_DIV  = 23'd1000;
    localparam logic [22:0] PCT_DIV = 23'd100;

    // Request opcodes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // Steering modes; the remaining codes add no steering.
    localparam logic [1:0] MODE_PROP = 2'd0;
    localparam logic [1:0] MODE_DIFF = 2'd1;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_T,
        S_DIV_E,
        S_MUL,
        S_NUM_GO,
        S_DIV_N,
        S_STEER,
        S_PROD_GO,
        S_DIV_S,
        S_MIX
    } t_state;

    // Request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [22:0] divisor;
    } t_div_req;

    // Response from the shared divider.
    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage

// ----- rtl/prsm_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module prsm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prsm_pkg::t_div_req i_req,
    output prsm_pkg::t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [22:0] r_rem;
    logic [31:0] r_quo;
    logic [22:0] r_div;

    logic [23:0] w_trial;
    logic [23:0] w_sub;
    logic        w_fit;
    logic [22:0] n_rem;

    // One trial subtraction of the divisor from the shifted remainder.
    always_comb begin
        w_trial = {r_rem, r_quo[31]};
        w_sub   = w_trial - {1'b0, r_div};
        w_fit   = (w_trial >= {1'b0, r_div});
        n_rem   = w_fit ? w_sub[22:0] : w_trial[22:0];
    end

    // Control: the run lasts 32 steps, then done pulses for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Data: the dividend shifts out at the top as quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[30:0], w_fit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- rtl/pwm_ramp_steering_mixer.sv -----
// Top level of the two-wheel drive mixer with a timed ramp of the base drive.
`timescale 1ns / 1ps

// Each request (a time tick or a set of target, ramp time, steering and mode)
// returns one result holding the left and right wheel drive. The base drive
// ramps in whole milliseconds from the previous to the current target and
// steering is mixed in according to the stored mode. Requests are processed
// one at a time: o_in_stall is high from acceptance until the result has been
// loaded into the output register. The wait is shortest when the ramp is
// finished and there is no proportional steering, and longest when the ramp is
// running with proportional steering. The sequencer runs the single 32-step
// restoring divider up to four times per request: ramp time and elapsed time to
// milliseconds, the ramp fraction, and the percentage of steering. A pending
// result in the output register does not block acceptance of the next request,
// but the next result waits, with the input still stalled, until the pending
// one has been taken.
// The tick period register may be written through the configuration channel at
// any time the block is idle; it resets to 1000 microseconds.
module pwm_ramp_steering_mixer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_opcode,
    input  logic signed [7:0]   i_target_pwm,
    input  logic signed [7:0]   i_steer_amount,
    input  logic [31:0]         i_ramp_time_us,
    input  logic [1:0]          i_steer_mode,
    // Result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [9:0]   o_left_drive,
    output logic signed [9:0]   o_right_drive,
    // Configuration channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [19:0]         i_cfg_data
);

    prsm_pkg::t_state   r_state;
    prsm_pkg::t_state   n_state;
    prsm_pkg::t_div_req w_div_req;
    prsm_pkg::t_div_rsp w_div_rsp;

    // Architectural state.
    logic [19:0]        r_tick;
    logic signed [7:0]  r_goal;
    logic signed [7:0]  r_prior;
    logic signed [7:0]  r_steer;
    logic [1:0]         r_mode;
    logic [31:0]        r_ramp;
    logic [31:0]        r_elapsed;

    // Working registers of one request.
    logic [22:0]        r_t_ms;
    logic [22:0]        r_e_ms;
    logic [31:0]        r_num;
    logic               r_num_neg;
    logic signed [9:0]  r_base;
    logic [16:0]        r_prod;
    logic               r_prod_neg;
    logic signed [9:0]  r_amt;

    // Output register.
    logic               r_out_valid;
    logic signed [9:0]  r_left;
    logic signed [9:0]  r_right;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_load_out;
    logic               w_ramp_over;
    logic [32:0]        w_tick_sum;
    logic [8:0]         w_diff;
    logic [8:0]         w_diff_abs;
    logic [22:0]        w_dt;
    logic [30:0]        w_num_prod;
    logic signed [9:0]  w_goal10;
    logic signed [9:0]  w_qn;
    logic [9:0]         w_base_abs;
    logic [8:0]         w_steer_abs;
    logic [15:0]        w_prod;
    logic signed [9:0]  w_amt_mag;
    logic signed [9:0]  w_mag10;
    logic signed [9:0]  w_left;
    logic signed [9:0]  w_right;
    logic               w_steer_pos;
    logic               w_steer_neg;
    logic [31:0]        w_q;

    prsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_q         = w_div_rsp.quotient;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_ramp_over = (r_ramp <= r_elapsed);
    assign o_cfg_ready = 1'b1;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            prsm_pkg::S_IDLE: begin
                if (w_in_acc) n_state = prsm_pkg::S_CHECK;
            end
            prsm_pkg::S_CHECK: begin
                n_state = w_ramp_over ? prsm_pkg::S_STEER : prsm_pkg::S_DIV_T;
            end
            prsm_pkg::S_DIV_T: begin
                if (w_div_rsp.done) begin
                    n_state = (w_q == 32'd0) ? prsm_pkg::S_STEER : prsm_pkg::S_DIV_E;
                end
            end
            prsm_pkg::S_DIV_E: begin
                if (w_div_rsp.done) n_state = prsm_pkg::S_MUL;
            end
            prsm_pkg::S_MUL:    n_state = prsm_pkg::S_NUM_GO;
            prsm_pkg::S_NUM_GO: n_state = prsm_pkg::S_DIV_N;
            prsm_pkg::S_DIV_N: begin
                if (w_div_rsp.done) n_state = prsm_pkg::S_STEER;
            end
            prsm_pkg::S_STEER: begin
                n_state = (r_mode == prsm_pkg::MODE_PROP) ? prsm_pkg::S_PROD_GO
                                                          : prsm_pkg::S_MIX;
            end
            prsm_pkg::S_PROD_GO: n_state = prsm_pkg::S_DIV_S;
            prsm_pkg::S_DIV_S: begin
                if (w_div_rsp.done) n_state = prsm_pkg::S_MIX;
            end
            prsm_pkg::S_MIX: begin
                if (w_out_free) n_state = prsm_pkg::S_IDLE;
            end
            default: n_state = prsm_pkg::S_IDLE;
        endcase
    end

    // Output logic of the sequencer: handshake, output load and divider requests.
    always_comb begin
        o_in_stall         = (r_state != prsm_pkg::S_IDLE);
        w_load_out         = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_ramp;
        w_div_req.divisor  = prsm_pkg::MS_DIV;
        case (r_state)
            prsm_pkg::S_CHECK: begin
                w_div_req.start = !w_ramp_over;
            end
            prsm_pkg::S_DIV_T: begin
                w_div_req.start    = w_div_rsp.done && (w_q != 32'd0);
                w_div_req.dividend = r_elapsed;
            end
            prsm_pkg::S_NUM_GO: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = r_num;
                w_div_req.divisor  = r_t_ms;
            end
            prsm_pkg::S_PROD_GO: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = {15'd0, r_prod};
                w_div_req.divisor  = prsm_pkg::PCT_DIV;
            end
            prsm_pkg::S_MIX: begin
                w_load_out = w_out_free;
            end
            default: begin
                w_load_out = 1'b0;
            end
        endcase
    end

    // Operands of the ramp and steering arithmetic.
    always_comb begin
        w_tick_sum  = {1'b0, r_elapsed} + {13'd0, r_tick};
        w_diff      = {r_goal[7], r_goal} - {r_prior[7], r_prior};
        w_diff_abs  = w_diff[8] ? (9'd0 - w_diff) : w_diff;
        w_dt        = r_t_ms - r_e_ms;
        w_num_prod  = w_diff_abs[7:0] * w_dt;
        w_goal10    = {{2{r_goal[7]}}, r_goal};
        w_qn        = {2'b00, w_q[7:0]};
        w_base_abs  = r_base[9] ? (10'd0 - r_base) : r_base;
        w_steer_abs = r_steer[7] ? (9'd0 - {r_steer[7], r_steer})
                                 : {r_steer[7], r_steer};
        w_prod      = w_base_abs[7:0] * w_steer_abs[7:0];
        w_amt_mag   = {1'b0, w_q[8:0]};
        w_mag10     = {2'b00, w_steer_abs[7:0]};
        w_steer_neg = r_steer[7];
        w_steer_pos = !r_steer[7] && (r_steer != 8'sd0);
    end

    // Steering mix of the finished base drive.
    always_comb begin
        w_left  = r_base;
        w_right = r_base;
        case (r_mode)
            prsm_pkg::MODE_PROP: begin
                if (w_steer_pos) w_right = r_base - r_amt;
                if (w_steer_neg) w_left  = r_base - r_amt;
            end
            prsm_pkg::MODE_DIFF: begin
                if (w_steer_pos) begin
                    w_left  = r_base + w_mag10;
                    w_right = r_base - w_mag10;
                end
                if (w_steer_neg) begin
                    w_left  = r_base - w_mag10;
                    w_right = r_base + w_mag10;
                end
            end
            default: begin
                w_left  = r_base;
                w_right = r_base;
            end
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prsm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Tick period register and stored drive parameters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= 20'd1000;
            r_goal    <= '0;
            r_prior   <= '0;
            r_steer   <= '0;
            r_mode    <= '0;
            r_ramp    <= '0;
            r_elapsed <= '0;
        end else begin
            if (i_cfg_valid) r_tick <= i_cfg_data;
            if (w_in_acc) begin
                if (i_opcode == prsm_pkg::OP_TICK) begin
                    // Elapsed time saturates at the top of its range.
                    r_elapsed <= w_tick_sum[32] ? 32'hFFFF_FFFF : w_tick_sum[31:0];
                end else begin
                    // A new target or ramp time restarts the ramp from the old target.
                    if ((i_target_pwm != r_goal) || (i_ramp_time_us != r_ramp)) begin
                        r_elapsed <= '0;
                        r_prior   <= r_goal;
                        r_goal    <= i_target_pwm;
                    end
                    r_steer <= i_steer_amount;
                    r_ramp  <= i_ramp_time_us;
                    r_mode  <= i_steer_mode;
                end
            end
        end
    end

    // Working registers, loaded step by step as the sequencer advances.
    always_ff @(posedge i_clk) begin
        case (r_state)
            prsm_pkg::S_CHECK: begin
                if (w_ramp_over) r_base <= w_goal10;
            end
            prsm_pkg::S_DIV_T: begin
                if (w_div_rsp.done) begin
                    r_t_ms <= w_q[22:0];
                    // A ramp shorter than a millisecond counts as finished.
                    if (w_q == 32'd0) r_base <= w_goal10;
                end
            end
            prsm_pkg::S_DIV_E: begin
                if (w_div_rsp.done) r_e_ms <= w_q[22:0];
            end
            prsm_pkg::S_MUL: begin
                r_num     <= {1'b0, w_num_prod};
                r_num_neg <= w_diff[8];
            end
            prsm_pkg::S_DIV_N: begin
                if (w_div_rsp.done) r_base <= w_goal10 - (r_num_neg ? -w_qn : w_qn);
            end
            prsm_pkg::S_STEER: begin
                r_prod     <= {w_prod, 1'b0};
                r_prod_neg <= r_base[9];
            end
            prsm_pkg::S_DIV_S: begin
                if (w_div_rsp.done) r_amt <= r_prod_neg ? -w_amt_mag : w_amt_mag;
            end
            default: begin
                r_base <= r_base;
            end
        endcase
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_left  <= w_left;
            r_right <= w_right;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_drive  = r_left;
    assign o_right_drive = r_right;

endmodule

// ----- rtl/prsm_checker.sv -----
// Port-level checker for the drive mixer and its bind to the top level.
`timescale 1ns / 1ps
`include "pwm_ramp_steering_mixer_assert.svh"

module prsm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [9:0]  o_left_drive,
    input logic signed [9:0]  o_right_drive
);

    // A stalled result keeps its valid and its drive values.
    `PRSM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_left_drive) && $stable(o_right_drive))

    // An accepted request keeps the block busy in the following cycle.
    `PRSM_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    // A new result only appears at the end of a request being processed.
    `PRSM_ASSERT_NOW(a_result_from_work, $rose(o_out_valid), $past(o_in_stall))

    // Drive values stay within the range of the drive law.
    `PRSM_ASSERT_NOW(a_drive_range, o_out_valid, (o_left_drive >= -300) && (o_left_drive <= 300) && (o_right_drive >= -300) && (o_right_drive <= 300))

endmodule

bind pwm_ramp_steering_mixer prsm_checker u_prsm_checker (.*);

// ----- sim/pwm_ramp_steering_mixer_tb.sv -----
// Self-checking testbench for the two-wheel drive mixer with a timed ramp.
`timescale 1ns / 1ps

module pwm_ramp_steering_mixer_tb;

    // Run control.
    localparam int HOLD_CYCLES = 600;
    localparam int STUCK_LIMIT = 4000;
    localparam int MAX_PRINTS  = 40;
    localparam int DRAIN_WAIT  = 150;

    // Steering modes that add no steering.
    localparam logic [1:0] MODE_OFF_A = 2'd2;
    localparam logic [1:0] MODE_OFF_B = 2'd3;

    // Scale factors of the drive law.
    localparam longint US_PER_MS  = 1000;
    localparam longint PERCENT    = 100;
    localparam longint STEER_GAIN = 2;

    typedef struct {
        logic              op;
        logic signed [7:0] target;
        logic signed [7:0] steer;
        logic [31:0]       ramp_us;
        logic [1:0]        mode;
    } t_mix_req;

    typedef struct {
        logic signed [9:0] left;
        logic signed [9:0] right;
    } t_drive_pair;

    // Block ports.
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_stall;
    logic              i_opcode       = prsm_pkg::OP_TICK;
    logic signed [7:0] i_target_pwm   = '0;
    logic signed [7:0] i_steer_amount = '0;
    logic [31:0]       i_ramp_time_us = '0;
    logic [1:0]        i_steer_mode   = prsm_pkg::MODE_PROP;
    logic              o_out_valid;
    logic              i_out_stall    = 1'b0;
    logic signed [9:0] o_left_drive;
    logic signed [9:0] o_right_drive;
    logic              i_cfg_valid    = 1'b0;
    logic              o_cfg_ready;
    logic [19:0]       i_cfg_data     = '0;

    // Request feed, expected drives and run bookkeeping.
    t_mix_req    feed_q[$];
    t_drive_pair drive_q[$];
    logic        in_took       = 1'b0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_asked    = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          err_count     = 0;
    int          stuck         = 0;

    // Generator memory of the last set request and the programmed period.
    logic signed [7:0] gen_tgt    = '0;
    logic [31:0]       gen_ramp   = '0;
    int                period_now = 1000;

    // Predictor state.
    logic [19:0]       tick_us;
    logic signed [7:0] tgt_now;
    logic signed [7:0] tgt_prev;
    logic signed [7:0] steer_now;
    logic [1:0]        mode_now;
    logic [31:0]       ramp_len_us;
    logic [31:0]       run_us;

    pwm_ramp_steering_mixer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_target_pwm   (i_target_pwm),
        .i_steer_amount (i_steer_amount),
        .i_ramp_time_us (i_ramp_time_us),
        .i_steer_mode   (i_steer_mode),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_drive   (o_left_drive),
        .o_right_drive  (o_right_drive),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advances the predicted state by one request and returns the wheel drives.
    function automatic t_drive_pair mix_step(input t_mix_req rq);
        longint      sum, base, diff, len_ms, at_ms, mag, amt, lft, rgt;
        t_drive_pair res;
        if (rq.op == prsm_pkg::OP_TICK) begin
            sum = longint'(run_us) + longint'(tick_us);
            run_us = (sum > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        end else begin
            // A new target or ramp time restarts the ramp from the old target.
            if (rq.target != tgt_now || rq.ramp_us != ramp_len_us) begin
                run_us   = '0;
                tgt_prev = tgt_now;
                tgt_now  = rq.target;
            end
            steer_now   = rq.steer;
            ramp_len_us = rq.ramp_us;
            mode_now    = rq.mode;
        end

        // Base drive; a ramp that has run out or is under a millisecond gives the target.
        len_ms = ramp_len_us / US_PER_MS;
        at_ms  = run_us / US_PER_MS;
        if (ramp_len_us <= run_us || len_ms == 0) begin
            base = longint'(tgt_now);
        end else begin
            diff = longint'(tgt_now) - longint'(tgt_prev);
            base = longint'(tgt_now) - diff * (len_ms - at_ms) / len_ms;
        end

        // Steering mix.
        mag = (steer_now < 0) ? -longint'(steer_now) : longint'(steer_now);
        lft = base;
        rgt = base;
        if (mode_now == prsm_pkg::MODE_PROP) begin
            amt = base * STEER_GAIN * mag / PERCENT;
            if (steer_now > 0) begin
                rgt = base - amt;
            end else if (steer_now < 0) begin
                lft = base - amt;
            end
        end else if (mode_now == prsm_pkg::MODE_DIFF) begin
            if (steer_now > 0) begin
                lft = base + mag;
                rgt = base - mag;
            end else if (steer_now < 0) begin
                lft = base - mag;
                rgt = base + mag;
            end
        end
        res.left  = lft[9:0];
        res.right = rgt[9:0];
        return res;
    endfunction

    task automatic report_error(input string msg);
        if (err_count < MAX_PRINTS) begin
            $display("%0t ns: %s", $time, msg);
        end
        err_count++;
    endtask

    function automatic t_mix_req set_req(input logic signed [7:0] tgt,
                                         input logic signed [7:0] st,
                                         input logic [31:0] ramp,
                                         input logic [1:0] md);
        t_mix_req rq;
        rq.op      = prsm_pkg::OP_SET;
        rq.target  = tgt;
        rq.steer   = st;
        rq.ramp_us = ramp;
        rq.mode    = md;
        gen_tgt    = tgt;
        gen_ramp   = ramp;
        return rq;
    endfunction

    // Ticks carry random values in the fields that they ignore.
    function automatic t_mix_req tick_req();
        t_mix_req rq;
        rq.op      = prsm_pkg::OP_TICK;
        rq.target  = 8'($urandom);
        rq.steer   = 8'($urandom);
        rq.ramp_us = $urandom;
        rq.mode    = 2'($urandom);
        return rq;
    endfunction

    // Random set request; ramps are mostly 1 to 12 times the larger of the tick period and 1 ms, plus under 2 ms.
    function automatic t_mix_req random_set();
        logic signed [7:0] tgt, st;
        logic [31:0]       ramp;
        int                step;
        case ($urandom_range(0, 7))
            0:       tgt = gen_tgt;
            1:       tgt = 8'($urandom);
            default: tgt = 8'($urandom_range(0, 200) - 100);
        endcase
        st   = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 200) - 100);
        step = (period_now > 1000) ? period_now : 1000;
        case ($urandom_range(0, 9))
            0:       ramp = $urandom;
            1:       ramp = $urandom_range(0, 999);
            2, 3:    ramp = gen_ramp;
            default: ramp = $urandom_range(1, 12) * step + $urandom_range(0, 1999);
        endcase
        return set_req(tgt, st, ramp, 2'($urandom));
    endfunction

    // Mostly a set followed by a run of ticks, with some stray ticks.
    task automatic random_run(input int count);
        int made;
        int ticks;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 9) == 0) begin
                feed_q.push_back(tick_req());
                made++;
            end else begin
                feed_q.push_back(random_set());
                made++;
                ticks = $urandom_range(0, 8);
                repeat (ticks) begin
                    feed_q.push_back(tick_req());
                    made++;
                end
            end
        end
    endtask

    // Returns once every request has been taken and every drive has arrived.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (feed_q.size() != 0 || (i_in_valid && !in_took) || drive_q.size() != 0);
    endtask

    task automatic write_tick_period(input logic [19:0] us);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= us;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        period_now = int'(us);
    endtask

    // Request driver: holds a stalled request, otherwise offers the next one at random.
    always @(negedge i_clk) begin
        t_mix_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_took) begin
            // The request waits unchanged until it is taken.
        end else if (feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = feed_q.pop_front();
            i_in_valid     <= 1'b1;
            i_opcode       <= nxt.op;
            i_target_pwm   <= nxt.target;
            i_steer_amount <= nxt.steer;
            i_ramp_time_us <= nxt.ramp_us;
            i_steer_mode   <= nxt.mode;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Result stall: random, or a long hold-off when one is asked for.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_served <= hold_asked;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Monitor: checks drives, tracks the register, predicts accepted requests.
    always @(posedge i_clk) begin
        t_drive_pair want;
        t_mix_req    seen;
        logic        moved;
        if (!i_rst_n) begin
            tick_us     = 20'd1000;
            tgt_now     = '0;
            tgt_prev    = '0;
            steer_now   = '0;
            mode_now    = prsm_pkg::MODE_PROP;
            ramp_len_us = '0;
            run_us      = '0;
            in_took    <= 1'b0;
            stuck       = 0;
        end else begin
            moved = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (drive_q.size() == 0) begin
                    report_error($sformatf("drive L=%0d R=%0d arrived with none expected",
                                           o_left_drive, o_right_drive));
                end else begin
                    want = drive_q.pop_front();
                    if (o_left_drive !== want.left) begin
                        report_error($sformatf("left drive %0d, expected %0d",
                                               o_left_drive, want.left));
                    end
                    if (o_right_drive !== want.right) begin
                        report_error($sformatf("right drive %0d, expected %0d",
                                               o_right_drive, want.right));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved   = 1'b1;
                tick_us = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                moved        = 1'b1;
                seen.op      = i_opcode;
                seen.target  = i_target_pwm;
                seen.steer   = i_steer_amount;
                seen.ramp_us = i_ramp_time_us;
                seen.mode    = i_steer_mode;
                drive_q.push_back(mix_step(seen));
            end
            in_took <= i_in_valid && !o_in_stall;

            // Watchdog over cycles with work outstanding and nothing moving.
            if (moved || (feed_q.size() == 0 && !i_in_valid && !i_cfg_valid
                          && drive_q.size() == 0)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
            if (stuck >= STUCK_LIMIT) begin
                $display("No progress for %0d cycles", STUCK_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily; reset tick period.
        send_idle_pct = 34;
        recv_idle_pct = 87;
        feed_q.push_back(tick_req());
        feed_q.push_back(set_req(8'sd100, 8'sd50, 32'd10000, prsm_pkg::MODE_PROP));
        repeat (3) feed_q.push_back(tick_req());
        // New target mid-ramp, full left steering.
        feed_q.push_back(set_req(-8'sd100, -8'sd100, 32'd4000, prsm_pkg::MODE_PROP));
        repeat (2) feed_q.push_back(tick_req());
        // Same target and ramp: only the mode changes, the ramp keeps running.
        feed_q.push_back(set_req(-8'sd100, -8'sd100, 32'd4000, prsm_pkg::MODE_DIFF));
        feed_q.push_back(set_req(-8'sd128, -8'sd128, 32'd5000, prsm_pkg::MODE_DIFF));
        feed_q.push_back(tick_req());
        feed_q.push_back(set_req(8'sd127, 8'sd127, 32'd5000, MODE_OFF_A));
        // Zero ramp and a ramp under a millisecond finish at once.
        feed_q.push_back(set_req(8'sd127, 8'sd127, 32'd0, MODE_OFF_B));
        feed_q.push_back(set_req(-8'sd50, 8'sd30, 32'd999, prsm_pkg::MODE_DIFF));
        // Longest ramp with no steering.
        feed_q.push_back(set_req(-8'sd50, 8'sd0, 32'hFFFF_FFFF, prsm_pkg::MODE_PROP));
        feed_q.push_back(tick_req());
        feed_q.push_back(set_req(-8'sd50, 8'sd0, 32'hFFFF_FFFF, prsm_pkg::MODE_DIFF));
        // Ramp that runs out exactly and then stays finished.
        feed_q.push_back(set_req(8'sd100, -8'sd128, 32'd2000, prsm_pkg::MODE_PROP));
        repeat (3) feed_q.push_back(tick_req());
        feed_q.push_back(set_req(-8'sd128, 8'sd127, 32'd1500, prsm_pkg::MODE_PROP));
        repeat (2) feed_q.push_back(tick_req());
        random_run(180);
        wait_drained();

        // Roles swapped; tick period of 1 microsecond, then of 1000000 microseconds.
        send_idle_pct = 87;
        recv_idle_pct = 34;
        write_tick_period(20'd1);
        random_run(100);
        wait_drained();
        write_tick_period(20'd1000000);
        random_run(100);
        wait_drained();

        // No idling; a zero period leaves the elapsed time still.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_tick_period(20'd0);
        random_run(50);
        wait_drained();
        write_tick_period(20'($urandom_range(2, 999999)));
        random_run(100);
        wait_drained();

        // Long receiver hold-off while requests keep coming, so the block backs up.
        hold_asked++;
        random_run(12);
        wait_drained();

        // Largest period moves the elapsed time in big steps along the longest ramp.
        write_tick_period(20'hFFFFF);
        feed_q.push_back(set_req(8'sd60, 8'sd20, 32'hFFFF_FFFF, MODE_OFF_A));
        repeat (8) feed_q.push_back(tick_req());
        feed_q.push_back(set_req(8'sd60, -8'sd20, 32'hFFFF_FFFF, prsm_pkg::MODE_DIFF));
        wait_drained();

        write_tick_period(20'd1000);
        random_run(60);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/prsm_pkg.sv
rtl/prsm_div.sv
rtl/pwm_ramp_steering_mixer.sv
rtl/prsm_checker.sv
sim/pwm_ramp_steering_mixer_tb.sv
